FILE: hw/rtl/gbfd_pkg.sv
// Shared types, constants and the byte-wide CRC-32 function for the frame deframer.
// Depends on nothing; the module files of the block refer to it by scoped names.
package gbfd_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 16;
   localparam int unsigned INDEX_W = 17;

   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h44;
   localparam logic [7:0] SYNC_C = 8'h12;
   localparam logic [7:0] MIN_HEADER = 8'd20;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [INDEX_W-1:0] CRC_BYTES = INDEX_W'(4);

   localparam logic [INDEX_W-1:0] IDX_HDR_LEN = INDEX_W'(3);
   localparam logic [INDEX_W-1:0] IDX_ID_LO = INDEX_W'(4);
   localparam logic [INDEX_W-1:0] IDX_ID_HI = INDEX_W'(5);
   localparam logic [INDEX_W-1:0] IDX_LEN_LO = INDEX_W'(8);
   localparam logic [INDEX_W-1:0] IDX_LEN_HI = INDEX_W'(9);
   localparam logic [INDEX_W-1:0] IDX_WEEK_FIRST = INDEX_W'(16);
   localparam logic [INDEX_W-1:0] IDX_WEEK_LAST = INDEX_W'(19);

   localparam logic [1:0] STATUS_CRC_GOOD = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd1;
   localparam logic [1:0] STATUS_SHORT_HEADER = 2'd2;

   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_SAW_A,
      PHASE_SAW_AB,
      PHASE_FRAME
   } phase_type;

   typedef struct packed {
      logic [1:0] frame_status;
      logic [15:0] message_id;
      logic [31:0] week_millis;
      logic [7:0] header_length;
      logic [15:0] message_length;
   } result_type;

   typedef struct packed {
      logic valid;
      logic [7:0] data_byte;
   } stage_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] t;
      t = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         if (t[0]) begin
            t = (t >> 1) ^ CRC_POLY;
         end else begin
            t = t >> 1;
         end
      end
      return {8'd0, crc[31:8]} ^ t;
   endfunction

   localparam logic [31:0] CRC_AFTER_SYNC =
      crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C);

endpackage

FILE: hw/rtl/gbfd_byte_if.sv
// Request channel carrying one received byte with a valid/ready handshake.
// Stands alone; used by the deframer top level.
interface gbfd_byte_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

FILE: hw/rtl/gbfd_result_if.sv
// Result channel carrying one frame report with a valid/ready handshake.
// Stands alone; used by the deframer top level.
interface gbfd_result_if;
   logic valid;
   logic ready;
   logic [1:0] frame_status;
   logic [15:0] message_id;
   logic [31:0] week_millis;
   logic [7:0] header_length;
   logic [15:0] message_length;

   modport source (output valid, output frame_status, output message_id,
                   output week_millis, output header_length, output message_length,
                   input ready);
   modport sink (input valid, input frame_status, input message_id,
                 input week_millis, input header_length, input message_length,
                 output ready);
endinterface

FILE: hw/rtl/gbfd_input_reg.sv
// Input register holding one accepted byte until the frame engine consumes it.
// Depends on gbfd_pkg for the stage type.
module gbfd_input_reg (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input logic [7:0] in_byte,
   output logic in_ready,
   input logic consume,
   output gbfd_pkg::stage_type stage
);

   logic valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic load;

   assign in_ready = !valid_ff || consume;
   assign load = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in = in_byte;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data_byte = byte_ff;

endmodule

FILE: hw/rtl/gbfd_frame_engine.sv
// Sync hunt, header field capture, CRC-32, frame end detection: one byte a cycle unless stalled.
// Depends on gbfd_pkg for the phase enum, constants and the CRC function.
module gbfd_frame_engine #(
   parameter int unsigned LENGTH_BITS = gbfd_pkg::LENGTH_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input gbfd_pkg::stage_type stage,
   input logic out_free,
   output logic consume,
   output logic res_valid,
   output gbfd_pkg::result_type res
);

   gbfd_pkg::phase_type phase_ff, phase_in;
   logic [gbfd_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [7:0] hdr_ff, hdr_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] id_ff, id_in;
   logic [31:0] week_ff, week_in;

   logic [7:0] b;
   logic [31:0] crc_next;
   logic [15:0] len_merge, len_wide;
   logic [gbfd_pkg::INDEX_W-1:0] total;
   logic sync_done, short_abort, frame_end, frame_done, has_result;

   assign b = stage.data_byte;
   assign crc_next = gbfd_pkg::crc_byte(crc_ff, b);
   assign sync_done = (phase_ff == gbfd_pkg::PHASE_SAW_AB) && (b == gbfd_pkg::SYNC_C);

   always_comb begin
      len_merge = '0;
      len_merge[LENGTH_BITS-1:0] = len_ff;
      if (index_ff == gbfd_pkg::IDX_LEN_LO) begin
         len_merge[7:0] = b;
      end
      if (index_ff == gbfd_pkg::IDX_LEN_HI) begin
         len_merge[15:8] = b;
      end
      len_wide = '0;
      len_wide[LENGTH_BITS-1:0] = len_merge[LENGTH_BITS-1:0];
   end

   always_comb begin
      hdr_in = hdr_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      id_in = id_ff;
      week_in = week_ff;
      index_in = index_ff;
      if (sync_done) begin
         index_in = gbfd_pkg::IDX_HDR_LEN;
         crc_in = gbfd_pkg::CRC_AFTER_SYNC;
         hdr_in = '0;
         len_in = '0;
         id_in = '0;
         week_in = '0;
      end else if (phase_ff == gbfd_pkg::PHASE_FRAME) begin
         crc_in = crc_next;
         len_in = len_merge[LENGTH_BITS-1:0];
         if (index_ff == gbfd_pkg::IDX_HDR_LEN) begin
            hdr_in = b;
         end
         if (index_ff == gbfd_pkg::IDX_ID_LO) begin
            id_in[7:0] = b;
         end
         if (index_ff == gbfd_pkg::IDX_ID_HI) begin
            id_in[15:8] = b;
         end
         if (index_ff >= gbfd_pkg::IDX_WEEK_FIRST && index_ff <= gbfd_pkg::IDX_WEEK_LAST) begin
            case (index_ff[1:0])
               2'd0: week_in[7:0] = b;
               2'd1: week_in[15:8] = b;
               2'd2: week_in[23:16] = b;
               2'd3: week_in[31:24] = b;
               default: week_in = week_ff;
            endcase
         end
      end
      total = gbfd_pkg::INDEX_W'(hdr_in) + gbfd_pkg::INDEX_W'(len_wide) + gbfd_pkg::CRC_BYTES;
      short_abort = (phase_ff == gbfd_pkg::PHASE_FRAME) &&
                    (index_ff == gbfd_pkg::IDX_HDR_LEN) && (b < gbfd_pkg::MIN_HEADER);
      frame_end = (phase_ff == gbfd_pkg::PHASE_FRAME) && (index_ff >= gbfd_pkg::IDX_ID_LO) &&
                  (({1'b0, index_ff} + 1'b1) >= {1'b0, total});
      frame_done = short_abort || frame_end;
      if (phase_ff == gbfd_pkg::PHASE_FRAME) begin
         index_in = frame_done ? '0 : index_ff + 1'b1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         gbfd_pkg::PHASE_HUNT: begin
            if (b == gbfd_pkg::SYNC_A) begin
               phase_in = gbfd_pkg::PHASE_SAW_A;
            end
         end
         gbfd_pkg::PHASE_SAW_A: begin
            if (b == gbfd_pkg::SYNC_B) begin
               phase_in = gbfd_pkg::PHASE_SAW_AB;
            end else if (b != gbfd_pkg::SYNC_A) begin
               phase_in = gbfd_pkg::PHASE_HUNT;
            end
         end
         gbfd_pkg::PHASE_SAW_AB: begin
            if (b == gbfd_pkg::SYNC_C) begin
               phase_in = gbfd_pkg::PHASE_FRAME;
            end else if (b == gbfd_pkg::SYNC_A) begin
               phase_in = gbfd_pkg::PHASE_SAW_A;
            end else begin
               phase_in = gbfd_pkg::PHASE_HUNT;
            end
         end
         gbfd_pkg::PHASE_FRAME: begin
            if (frame_done) begin
               phase_in = gbfd_pkg::PHASE_HUNT;
            end
         end
         default: phase_in = gbfd_pkg::PHASE_HUNT;
      endcase
   end

   always_comb begin
      has_result = frame_done;
      consume = stage.valid && (!has_result || out_free);
      res_valid = consume && has_result;
      if (short_abort) begin
         res.frame_status = gbfd_pkg::STATUS_SHORT_HEADER;
         res.message_id = '0;
         res.week_millis = '0;
         res.header_length = b;
         res.message_length = '0;
      end else begin
         res.frame_status = (crc_next == 32'd0) ? gbfd_pkg::STATUS_CRC_GOOD
                                                : gbfd_pkg::STATUS_CRC_BAD;
         res.message_id = id_in;
         res.week_millis = week_in;
         res.header_length = hdr_in;
         res.message_length = len_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gbfd_pkg::PHASE_HUNT;
         index_ff <= '0;
         hdr_ff <= '0;
         len_ff <= '0;
         crc_ff <= '0;
         id_ff <= '0;
         week_ff <= '0;
      end else if (consume) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         hdr_ff <= hdr_in;
         len_ff <= len_in;
         crc_ff <= crc_in;
         id_ff <= id_in;
         week_ff <= week_in;
      end
   end

endmodule

FILE: hw/rtl/gbfd_result_reg.sv
// Result register presenting one frame report until the consumer takes it.
// Depends on gbfd_pkg for the result type.
module gbfd_result_reg (
   input logic clock,
   input logic reset,
   input logic res_valid,
   input gbfd_pkg::result_type res,
   output logic out_free,
   output logic out_valid,
   input logic out_ready,
   output gbfd_pkg::result_type out_res
);

   logic valid_ff, valid_in;
   gbfd_pkg::result_type res_ff, res_in;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in = res_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         res_in = res;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res = res_ff;

endmodule

FILE: hw/rtl/gnss_binary_frame_deframer_crc32.sv
// Top level of the sync-headed binary frame deframer with CRC-32 check.
// Depends on gbfd_pkg, gbfd_byte_if, gbfd_result_if and the three gbfd_ stage modules.
//
// Channel    Direction  Request contents
// req_chan   in         data_byte: one received serial byte
// rsp_chan   out        frame_status, message_id, week_millis, header_length, message_length
//
// One byte is accepted every cycle unless the engine stalls; each byte passes the input
// register, is processed by the frame engine, and a frame report appears in the result
// register the cycle after the last frame byte is processed.
// The engine stalls only when it must emit a report and the result register is still full.
// Synchronous active-high reset returns the engine to sync hunting and empties both registers.
module gnss_binary_frame_deframer_crc32 #(
   parameter int unsigned LENGTH_BITS = gbfd_pkg::LENGTH_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   gbfd_byte_if.sink req_chan,
   gbfd_result_if.source rsp_chan
);

   gbfd_pkg::stage_type stage;
   gbfd_pkg::result_type res, out_res;
   logic consume, res_valid, out_free;

   gbfd_input_reg u_input_reg (
      .clock(clock),
      .reset(reset),
      .in_valid(req_chan.valid),
      .in_byte(req_chan.data_byte),
      .in_ready(req_chan.ready),
      .consume(consume),
      .stage(stage)
   );

   gbfd_frame_engine #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_frame_engine (
      .clock(clock),
      .reset(reset),
      .stage(stage),
      .out_free(out_free),
      .consume(consume),
      .res_valid(res_valid),
      .res(res)
   );

   gbfd_result_reg u_result_reg (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res(res),
      .out_free(out_free),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .out_res(out_res)
   );

   assign rsp_chan.frame_status = out_res.frame_status;
   assign rsp_chan.message_id = out_res.message_id;
   assign rsp_chan.week_millis = out_res.week_millis;
   assign rsp_chan.header_length = out_res.header_length;
   assign rsp_chan.message_length = out_res.message_length;

endmodule
